>>> rtl/conv2d_3x3_valid_top_macros.svh
// assertion helpers for the checker file c2v_chk.sv
`ifndef CONV2D_3X3_VALID_TOP_MACROS_SVH
`define CONV2D_3X3_VALID_TOP_MACROS_SVH

// same-cycle implication, masked while reset is active
`define C2V_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, masked while reset is active
`define C2V_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

// implication that is also checked during reset
`define C2V_ASSERT_PLAIN(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed: reset check");

`endif

>>> rtl/c2v_pkg.sv
`default_nettype none

package c2v_pkg;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int TAPS      = 3;
    localparam int PROD_W    = 24;
    localparam int COLSUM_W  = 26;
    localparam int SUM_W     = 28;
    localparam int POS_W     = 10;
    localparam int DIM_W     = 11;
    localparam int CFG_W     = 48;
    localparam int IDX_W     = 3;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [DIM_W-1:0] DIM_RESET  = 11'd5;
    localparam logic [CFG_W-1:0] COEF_RESET = 48'h0100_0000_FF00;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_ROW0    = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_ROW1    = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_ROW2    = 3'd4;

    typedef logic [PIX_W-1:0]               pix_t;
    typedef logic [TAPS-1:0][PIX_W-1:0]     pix_col_t;
    typedef logic [TAPS-1:0][COEF_W-1:0]    coef_col_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [COLSUM_W-1:0]     colsum_t;
    typedef logic signed [SUM_W-1:0]        sum_t;

    // enables for the window column cells, one per pipeline step
    typedef struct packed {
        logic shift;
        logic mult;
        logic sum;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/conv2d_3x3_valid_top.sv
// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready       | tdata: pixel; tuser: frame_start
// m_axis    | out | m_axis_tvalid/tready       | tdata: filtered, out_row, out_col; tlast
// wr        | in  | wr_en (no wait)            | wr_index, wr_data
//
// one pixel per clock sustained while the output queue is not full; the path of a result from its pixel
// is line memory read, window cells, products, column sums, chain sum, output queue
// s_axis_tready drops only while the 2-entry output queue is full
// rst_n clears control and configuration at once; the line memory needs no clearing,
// since rows 0 and 1 of every image rewrite it before any result reads it
`default_nettype none

module conv2d_3x3_valid_top #(
    parameter int MAX_WIDTH  = c2v_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c2v_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [c2v_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [7:0] pixel
    input  logic                             s_axis_tuser,   // [0] frame_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [c2v_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [27:0] filtered,
                                                             // [37:28] out_row,
                                                             // [47:38] out_col
    output logic                             m_axis_tlast,   // frame_end
    input  logic                             wr_en,
    input  logic [c2v_pkg::IDX_W-1:0]        wr_index,
    input  logic [c2v_pkg::CFG_W-1:0]        wr_data
);

    import c2v_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int NSTAGE = 5;

    typedef struct packed {
        logic             produce;
        logic             frame_end;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } meta_t;

    typedef struct packed {
        logic                  last;
        logic [OUT_DATA_W-1:0] data;
    } res_t;

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [CFG_W-1:0] coef_reg [TAPS];
    logic [WW-1:0]    w_use;
    logic [HW-1:0]    h_use;

    // position
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] c0;
    logic [RW-1:0] r0;
    logic          col_last, row_last;
    meta_t         meta0;

    // pipeline
    logic              adv, accept;
    logic [NSTAGE:1]   vld_reg;
    meta_t             meta_reg [1:NSTAGE];
    pix_t              px1_reg;
    logic [CW-1:0]     addr1_reg;
    logic [LINE_W-1:0] line_rdata;
    logic [LINE_W-1:0] line_wdata;
    logic              line_we;
    pix_col_t          new_col;
    pix_col_t          link21, link10;
    coef_col_t         coef_col [TAPS];
    cell_ctrl_t        cell_ctrl;
    sum_t              psum0, psum1, psum2;
    sum_t              total_reg;

    // output queue
    res_t       obuf_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    res_t       res_in;

    always_comb
    begin
        if (width_reg < DIM_W'(3))
            w_use = WW'(3);
        else if (32'(width_reg) > MAX_WIDTH)
            w_use = WW'(MAX_WIDTH);
        else
            w_use = WW'(width_reg);
        if (height_reg < DIM_W'(3))
            h_use = HW'(3);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_use = HW'(MAX_HEIGHT);
        else
            h_use = HW'(height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            for (int i = 0; i < TAPS; i++)
            begin
                coef_reg[i] <= COEF_RESET;
            end
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_IMAGE_WIDTH:  width_reg   <= wr_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= wr_data[DIM_W-1:0];
                REG_COEF_ROW0:    coef_reg[0] <= wr_data;
                REG_COEF_ROW1:    coef_reg[1] <= wr_data;
                REG_COEF_ROW2:    coef_reg[2] <= wr_data;
                default:          ;
            endcase
        end
    end

    assign adv           = (count_reg != 2'd2);
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // position of the incoming pixel; frame_start restarts it
    always_comb
    begin
        c0       = s_axis_tuser ? '0 : col_reg;
        r0       = s_axis_tuser ? '0 : row_reg;
        col_last = (WW'(c0) == w_use - WW'(1));
        row_last = (HW'(r0) == h_use - HW'(1));
        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : r0 + RW'(1);
        end
        else
        begin
            col_next = c0 + CW'(1);
            row_next = r0;
        end
        meta0.produce   = (r0 >= RW'(2)) && (c0 >= CW'(2));
        meta0.frame_end = row_last && col_last;
        meta0.row       = POS_W'(r0 - RW'(2));
        meta0.col       = POS_W'(c0 - CW'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (wr_en && (wr_index == REG_IMAGE_WIDTH || wr_index == REG_IMAGE_HEIGHT))
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTAGE-1:1], accept};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                meta_reg[1] <= meta0;
                px1_reg     <= s_axis_tdata[PIX_W-1:0];
                addr1_reg   <= c0;
            end
            for (int k = 2; k <= NSTAGE; k++)
            begin
                meta_reg[k] <= meta_reg[k-1];
            end
            if (vld_reg[NSTAGE-1])
            begin
                total_reg <= psum2;
            end
        end
    end

    // both line stores side by side: low byte two rows up, high byte one row up
    assign line_we    = adv && vld_reg[1];
    assign line_wdata = {px1_reg, line_rdata[LINE_W-1:PIX_W]};
    assign new_col    = {px1_reg, line_rdata[LINE_W-1:PIX_W], line_rdata[PIX_W-1:0]};

    c2v_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (addr1_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (c0),
        .rdata (line_rdata)
    );

    always_comb
    begin
        for (int kj = 0; kj < TAPS; kj++)
        begin
            for (int ki = 0; ki < TAPS; ki++)
            begin
                coef_col[kj][ki] = coef_reg[ki][COEF_W*kj +: COEF_W];
            end
        end
    end

    assign cell_ctrl.shift = adv && vld_reg[1];
    assign cell_ctrl.mult  = adv && vld_reg[2];
    assign cell_ctrl.sum   = adv && vld_reg[3];

    // newest column enters on the right and moves left
    c2v_cell u_col2 (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .col_in   (new_col),
        .coef_in  (coef_col[2]),
        .psum_in  (psum1),
        .col_out  (link21),
        .psum_out (psum2)
    );

    c2v_cell u_col1 (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .col_in   (link21),
        .coef_in  (coef_col[1]),
        .psum_in  (psum0),
        .col_out  (link10),
        .psum_out (psum1)
    );

    c2v_cell u_col0 (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .col_in   (link10),
        .coef_in  (coef_col[0]),
        .psum_in  ('0),
        .col_out  (),
        .psum_out (psum0)
    );

    // output queue
    assign push = adv && vld_reg[NSTAGE] && meta_reg[NSTAGE].produce;
    assign pop  = m_axis_tvalid && m_axis_tready;

    assign res_in.last = meta_reg[NSTAGE].frame_end;
    assign res_in.data = {meta_reg[NSTAGE].col, meta_reg[NSTAGE].row, total_reg};

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            obuf_reg[wptr_reg] <= res_in;
        end
    end

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = obuf_reg[rptr_reg].data;
    assign m_axis_tlast  = obuf_reg[rptr_reg].last;

endmodule

`default_nettype wire

>>> rtl/c2v_ram.sv
`default_nettype none

module c2v_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/c2v_cell.sv
`default_nettype none

module c2v_cell (
    input  logic                  clk,
    input  c2v_pkg::cell_ctrl_t   ctrl,
    input  c2v_pkg::pix_col_t     col_in,
    input  c2v_pkg::coef_col_t    coef_in,
    input  c2v_pkg::sum_t         psum_in,
    output c2v_pkg::pix_col_t     col_out,
    output c2v_pkg::sum_t         psum_out
);

    import c2v_pkg::*;

    pix_col_t col_reg;
    prod_t    prod_reg [TAPS];
    colsum_t  colsum_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
        if (ctrl.mult)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                // unsigned pixel times signed coefficient
                prod_reg[i] <= PROD_W'($signed({1'b0, col_reg[i]}) * $signed(coef_in[i]));
            end
        end
        if (ctrl.sum)
        begin
            colsum_reg <= COLSUM_W'(prod_reg[0]) + COLSUM_W'(prod_reg[1])
                        + COLSUM_W'(prod_reg[2]);
        end
    end

    assign col_out  = col_reg;
    assign psum_out = psum_in + SUM_W'(colsum_reg);

endmodule

`default_nettype wire

>>> rtl/c2v_chk.sv
`default_nettype none
`include "conv2d_3x3_valid_top_macros.svh"

module c2v_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled result stays offered
    `C2V_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // and keeps its payload
    `C2V_ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                     $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // input backpressure only when results are waiting downstream
    `C2V_ASSERT_IMPL(a_stall_backed, clk, rst_n, !s_axis_tready, m_axis_tvalid)

    // nothing offered while in reset
    `C2V_ASSERT_PLAIN(a_reset_quiet, clk, !rst_n, !m_axis_tvalid)

endmodule

bind conv2d_3x3_valid_top c2v_chk u_c2v_chk (.*);

`default_nettype wire
